>>> src/kvht_pkg.sv
// Shared types, field widths and codes for the key/value hint table.
// No dependencies; every other file in src refers to this package by scoped names.
`default_nettype none

package kvht_pkg;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 64;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;

    localparam int DEPTH_DEFAULT = 16;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [STAT_W-1:0]  status_t;

    localparam count_t CNT_ONE   = 5'd1;
    localparam count_t CAP_RESET = 5'd16;

    // request opcodes
    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    // result status codes
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_MISS = 2'd2;

    // enables from the sequencer to the entry store
    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic val_we;
    } mem_ctl_t;

endpackage

`default_nettype wire

>>> src/kvht_req_if.sv
// Request channel of the key/value hint table: valid/ready plus request payload.
// Depends on kvht_pkg for the payload types.
`default_nettype none

interface kvht_req_if;

    logic            valid;
    logic            ready;
    logic            opcode;
    kvht_pkg::key_t   key;
    kvht_pkg::value_t write_value;

    modport source (output valid, output opcode, output key, output write_value, input ready);
    modport sink   (input valid, input opcode, input key, input write_value, output ready);

endinterface

`default_nettype wire

>>> src/kvht_rsp_if.sv
// Response channel of the key/value hint table: valid/ready plus result payload.
// Depends on kvht_pkg for the payload types.
`default_nettype none

interface kvht_rsp_if;

    logic              valid;
    logic              ready;
    kvht_pkg::status_t status;
    kvht_pkg::value_t  read_value;
    kvht_pkg::count_t  entries_used;

    modport source (output valid, output status, output read_value, output entries_used,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entries_used,
                    output ready);

endinterface

`default_nettype wire

>>> src/key_value_hint_table.sv
// Top level of the key/value hint table: sequencer, comparator, result register.
// Depends on kvht_pkg, kvht_req_if, kvht_rsp_if and kvht_store.
//
// The table holds up to ENTRIES pairs of a 16-bit key and a 64-bit value, filled in order
// from entry 0. A set (opcode 0) overwrites the value of a matching key, or appends a new
// entry, or answers "table full" once the used count has reached min(capacity_in_use,
// ENTRIES). A get (opcode 1) returns the stored value or answers "not found". Every
// request yields exactly one response transfer. One request is worked on at a time: the
// request is taken, then a single 16-bit comparator walks the key memory one entry per
// cycle (the read port is pipelined one entry ahead of the compare), and a last step
// writes the memory and loads the response register; that last step waits while the
// previous response has not been taken. The response register lets a new request transfer
// while the last result still waits. Entries are never cleared: after reset only the used
// count is zero, and only entries below it are read, so no clearing pass follows reset.
// capacity_in_use must be written through cfg_write_en / cfg_write_data only while the
// table is idle (the block does not enforce this); it resets to 16.
`default_nettype none

module key_value_hint_table #(
    parameter int ENTRIES = kvht_pkg::DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    kvht_req_if.sink              req,
    kvht_rsp_if.source            rsp,
    input  wire logic             cfg_write_en,
    input  wire kvht_pkg::count_t cfg_write_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    // configuration and table occupancy
    kvht_pkg::count_t cap_reg;
    kvht_pkg::count_t used_reg, used_next;

    // request being worked on
    logic             op_reg;
    kvht_pkg::key_t   key_reg;
    kvht_pkg::value_t wval_reg;

    // scan pointers: issue_idx leads the read port, cmp_idx names the entry under compare
    kvht_pkg::count_t issue_idx_reg, issue_idx_next;
    kvht_pkg::count_t cmp_idx_reg, cmp_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             hit_reg, hit_next;

    // response register
    logic              rsp_valid_reg, rsp_valid_next;
    kvht_pkg::status_t rsp_status_reg, rsp_status_next;
    kvht_pkg::value_t  rsp_value_reg, rsp_value_next;
    kvht_pkg::count_t  rsp_used_reg, rsp_used_next;

    // store interface
    kvht_pkg::mem_ctl_t mem_ctl;
    logic [IDX_W-1:0]   mem_addr;
    kvht_pkg::key_t     rd_key;
    kvht_pkg::value_t   rd_value;

    logic key_match;
    logic table_full;
    logic rsp_slot_free;
    logic req_fire;

    kvht_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk      (clk),
        .ctl      (mem_ctl),
        .addr     (mem_addr),
        .wr_key   (key_reg),
        .wr_value (wval_reg),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // the one shared comparator
    assign key_match = cmp_valid_reg && (rd_key == key_reg);

    // full once used reaches the configured capacity or the built depth
    assign table_full = (used_reg >= cap_reg) || (32'(used_reg) >= ENTRIES);

    assign rsp_slot_free = !rsp_valid_reg || rsp.ready;
    assign req.ready     = (state_reg == S_IDLE);
    assign req_fire      = req.valid && req.ready;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        hit_next        = hit_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_used_next   = rsp_used_reg;
        mem_ctl         = '0;
        mem_addr        = IDX_W'(issue_idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    issue_idx_next = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (key_match)
                begin
                    // hold cmp_idx: it names the matching entry
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (issue_idx_reg == used_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    // read the next entry while the previous one is compared
                    mem_ctl.rd_en  = 1'b1;
                    cmp_idx_next   = issue_idx_reg;
                    cmp_valid_next = 1'b1;
                    issue_idx_next = issue_idx_reg + kvht_pkg::CNT_ONE;
                end
            end
            S_DONE:
            begin
                mem_addr = hit_reg ? IDX_W'(cmp_idx_reg) : IDX_W'(used_reg);
                if (rsp_slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = kvht_pkg::ST_OK;
                    rsp_value_next  = '0;
                    rsp_used_next   = used_reg;
                    if (op_reg == kvht_pkg::OP_SET)
                    begin
                        if (hit_reg)
                        begin
                            mem_ctl.val_we = 1'b1;
                        end
                        else if (table_full)
                        begin
                            rsp_status_next = kvht_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_ctl.key_we = 1'b1;
                            mem_ctl.val_we = 1'b1;
                            used_next      = used_reg + kvht_pkg::CNT_ONE;
                            rsp_used_next  = used_reg + kvht_pkg::CNT_ONE;
                        end
                    end
                    else
                    begin
                        if (hit_reg)
                        begin
                            rsp_value_next = rd_value;
                        end
                        else
                        begin
                            rsp_status_next = kvht_pkg::ST_MISS;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            cap_reg       <= kvht_pkg::CAP_RESET;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            issue_idx_reg <= '0;
            cmp_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
            issue_idx_reg <= issue_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
        end
    end

    // payload: request capture and response register
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg   <= req.opcode;
            key_reg  <= req.key;
            wval_reg <= req.write_value;
        end
        rsp_status_reg <= rsp_status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_used_reg   <= rsp_used_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.read_value   = rsp_value_reg;
    assign rsp.entries_used = rsp_used_reg;

    // the used count only ever grows by one entry at a time
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + kvht_pkg::CNT_ONE))
        else $error("used count moved by other than one");

    // the table never holds more than its built depth
    a_used_depth: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= ENTRIES)
        else $error("used count beyond table depth");

    // the scan never reads past the used entries
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_idx_reg <= used_reg))
        else $error("scan pointer beyond used entries");

    // a failed request returns a zero value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg != kvht_pkg::ST_OK)) |-> (rsp_value_reg == '0))
        else $error("non-zero value on failed request");

endmodule

`default_nettype wire

>>> src/kvht_store.sv
// Entry store: key memory and value memory sharing one address, registered read.
// Depends on kvht_pkg for payload types and the control struct.
`default_nettype none

module kvht_store #(
    parameter int ENTRIES = kvht_pkg::DEPTH_DEFAULT,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic              clk,
    input  wire kvht_pkg::mem_ctl_t ctl,
    input  wire logic [IDX_W-1:0]  addr,
    input  wire kvht_pkg::key_t    wr_key,
    input  wire kvht_pkg::value_t  wr_value,
    output kvht_pkg::key_t         rd_key,
    output kvht_pkg::value_t       rd_value
);

    kvht_pkg::key_t   key_mem [ENTRIES];
    kvht_pkg::value_t val_mem [ENTRIES];

    kvht_pkg::key_t   rd_key_reg;
    kvht_pkg::value_t rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[addr] <= wr_key;
        end
        if (ctl.val_we)
        begin
            val_mem[addr] <= wr_value;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg   <= key_mem[addr];
            rd_value_reg <= val_mem[addr];
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

`default_nettype wire
